FILE: src/sliding_window_median_top_defines.svh
// Assertion helpers for the running median block.
`ifndef SLIDING_WINDOW_MEDIAN_TOP_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SWM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("running median check failed");

// Check that cons holds in the cycle after ante.
`define SWM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("running median check failed");

`endif

FILE: src/swm_pkg.sv
package swm_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int CFG_BITS    = 7;
    localparam int IDX_BITS    = $clog2(MAX_WINDOW);
    localparam int CNT_BITS    = $clog2(MAX_WINDOW + 1);
    localparam int MED_BITS    = SAMPLE_BITS + 1;

    localparam logic KIND_SAMPLE = 1'b0;

    // Sorted cell contents: sample value and age in slots since it entered.
    typedef struct packed {
        logic                          valid;
        logic signed [SAMPLE_BITS-1:0] value;
        logic [IDX_BITS-1:0]           age;
    } swm_cell_t;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic                          step;
        logic                          clear;
        logic                          ins;
        logic [IDX_BITS-1:0]           evict_age;
        logic signed [SAMPLE_BITS-1:0] sample;
    } swm_ctrl_t;

    // Age at which a sample leaves the window, from the written length.
    function automatic logic [IDX_BITS-1:0] swm_last_age(input logic [CFG_BITS-1:0] wl);
        logic [IDX_BITS-1:0] res;
        if (wl == '0)
        begin
            res = '0;
        end
        else if (wl > CFG_BITS'(MAX_WINDOW))
        begin
            res = IDX_BITS'(MAX_WINDOW - 1);
        end
        else
        begin
            res = IDX_BITS'(wl - 1'b1);
        end
        return res;
    endfunction

endpackage

FILE: src/swm_sample_if.sv
interface swm_sample_if
    import swm_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output kind, output sample, input ready);
    modport sink (input valid, input kind, input sample, output ready);
endinterface

FILE: src/swm_median_if.sv
interface swm_median_if
    import swm_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [MED_BITS-1:0] median_half_units;
    logic                       median_valid;
    logic [CNT_BITS-1:0]        valid_samples;

    modport source (output valid, output median_half_units, output median_valid,
                    output valid_samples, input ready);
    modport sink (input valid, input median_half_units, input median_valid,
                  input valid_samples, output ready);
endinterface

FILE: src/swm_cell.sv
module swm_cell
    import swm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  swm_ctrl_t ctrl,
    input  swm_cell_t left_cell,
    input  logic      left_shift,
    input  logic      left_bigp,
    input  swm_cell_t right_cell,
    input  logic      right_big,
    output swm_cell_t own_cell,
    output logic      big,
    output logic      shift,
    output logic      bigp
);

    logic                          valid_reg;
    logic                          valid_next;
    logic signed [SAMPLE_BITS-1:0] value_reg;
    logic signed [SAMPLE_BITS-1:0] value_next;
    logic [IDX_BITS-1:0]           age_reg;
    logic [IDX_BITS-1:0]           age_next;
    logic                          evict;
    swm_cell_t                     r_self;
    swm_cell_t                     r_left;

    assign own_cell = '{valid: valid_reg, value: value_reg, age: age_reg};

    // Empty cells sort above every sample.
    assign big   = !valid_reg || ($signed(value_reg) > $signed(ctrl.sample));
    assign evict = valid_reg && (age_reg == ctrl.evict_age);

    // Close the gap left by the evicted entry: cells at or above it pull from the right.
    assign shift  = left_shift | evict;
    assign r_self = shift ? right_cell : own_cell;
    assign bigp   = shift ? right_big : big;
    assign r_left = left_shift ? own_cell : left_cell;

    always_comb
    begin
        if (ctrl.ins && bigp && !left_bigp)
        begin
            valid_next = 1'b1;
            value_next = ctrl.sample;
            age_next   = '0;
        end
        else if (ctrl.ins && bigp)
        begin
            valid_next = r_left.valid;
            value_next = r_left.value;
            age_next   = r_left.age + 1'b1;
        end
        else
        begin
            valid_next = r_self.valid;
            value_next = r_self.value;
            age_next   = r_self.age + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.step)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

endmodule

FILE: src/sliding_window_median_top.sv
// Running median over the last window_len slots (1 to 64, reset 64). Each request on
// sample_ch is a sample (kind 0) or a skip (kind 1, a missing slot); each one returns
// exactly one result on median_ch: twice the median of the samples now in the window
// (sum of the two middle values for an even count), median_valid, and the sample count.
// An empty window reports 0 with median_valid low. The samples are kept in ascending
// order in a row of 64 cells; every cell also tracks how many slots ago its sample came
// in, so the sample that leaves the window is found by its age. Eviction and insertion
// both complete in the cycle a request is taken; the median is then read out of the
// cells and registered once the output register is free or being taken, and a new
// request is taken every cycle as long as median_ch takes results.
// The cell row update sets the one-request-per-cycle rate. A write on cfg_we sets
// window_len and empties the window; write only while no request is in flight.
module sliding_window_median_top
    import swm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_BITS-1:0] cfg_wdata,
    swm_sample_if.sink          sample_ch,
    swm_median_if.source        median_ch
);

    // Window length, held as the age at which a sample drops out.
    logic [IDX_BITS-1:0] last_age_reg;

    // Flow control: pend_reg marks cells that hold an update not yet reported.
    logic pend_reg;
    logic pend_next;
    logic out_valid_reg;
    logic load_out;
    logic accept;

    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;

    logic signed [MED_BITS-1:0] med_reg;
    logic signed [MED_BITS-1:0] med_next;
    logic                       mvalid_reg;
    logic [CNT_BITS-1:0]        cnt_out_reg;

    swm_ctrl_t ctrl;

    swm_cell_t cell_q  [MAX_WINDOW];
    logic      big_w   [MAX_WINDOW];
    logic      shift_w [MAX_WINDOW];
    logic      bigp_w  [MAX_WINDOW];

    logic [IDX_BITS-1:0]           lo_idx;
    logic [IDX_BITS-1:0]           hi_idx;
    logic signed [SAMPLE_BITS-1:0] lo_val;
    logic signed [SAMPLE_BITS-1:0] hi_val;

    // Move the pending result to the output register when it is free or being taken.
    assign load_out        = pend_reg && (!out_valid_reg || median_ch.ready);
    assign sample_ch.ready = !pend_reg || load_out;
    assign accept          = sample_ch.valid && sample_ch.ready;

    assign ctrl = '{step:      accept,
                    clear:     cfg_we,
                    ins:       (sample_ch.kind == KIND_SAMPLE),
                    evict_age: last_age_reg,
                    sample:    sample_ch.sample};

    // Sorted cell row; neighbors trade values and the eviction shift flag every step.
    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        swm_cell_t left_cell;
        logic      left_shift;
        logic      left_bigp;
        swm_cell_t right_cell;
        logic      right_big;

        if (i == 0)
        begin : g_first
            assign left_cell  = '0;
            assign left_shift = 1'b0;
            assign left_bigp  = 1'b0;
        end
        else
        begin : g_mid_left
            assign left_cell  = cell_q[i-1];
            assign left_shift = shift_w[i-1];
            assign left_bigp  = bigp_w[i-1];
        end

        if (i == MAX_WINDOW - 1)
        begin : g_last
            assign right_cell = '0;
            assign right_big  = 1'b1;
        end
        else
        begin : g_mid_right
            assign right_cell = cell_q[i+1];
            assign right_big  = big_w[i+1];
        end

        swm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .left_cell  (left_cell),
            .left_shift (left_shift),
            .left_bigp  (left_bigp),
            .right_cell (right_cell),
            .right_big  (right_big),
            .own_cell   (cell_q[i]),
            .big        (big_w[i]),
            .shift      (shift_w[i]),
            .bigp       (bigp_w[i])
        );
    end

    // Sample count: drop one if a cell evicted, add one for a new sample.
    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            count_next = count_reg - CNT_BITS'(shift_w[MAX_WINDOW-1])
                       + CNT_BITS'(ctrl.ins);
        end
    end

    // Middle entries; for an odd count both indexes land on the same cell.
    assign lo_idx = IDX_BITS'((count_reg - 1'b1) >> 1);
    assign hi_idx = IDX_BITS'(count_reg >> 1);

    always_comb
    begin
        lo_val = '0;
        hi_val = '0;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            lo_val = lo_val | (cell_q[i].value & {SAMPLE_BITS{IDX_BITS'(i) == lo_idx}});
            hi_val = hi_val | (cell_q[i].value & {SAMPLE_BITS{IDX_BITS'(i) == hi_idx}});
        end
    end

    always_comb
    begin
        if (count_reg == '0)
        begin
            med_next = '0;
        end
        else
        begin
            med_next = {lo_val[SAMPLE_BITS-1], lo_val} + {hi_val[SAMPLE_BITS-1], hi_val};
        end
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (accept)
        begin
            pend_next = 1'b1;
        end
        else if (load_out)
        begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_age_reg  <= IDX_BITS'(MAX_WINDOW - 1);
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (cfg_we)
            begin
                last_age_reg <= swm_last_age(cfg_wdata);
                count_reg    <= '0;
            end
            else
            begin
                count_reg <= count_next;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (median_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result payload until it is taken.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            med_reg     <= med_next;
            mvalid_reg  <= (count_reg != '0);
            cnt_out_reg <= count_reg;
        end
    end

    assign median_ch.valid             = out_valid_reg;
    assign median_ch.median_half_units = med_reg;
    assign median_ch.median_valid      = mvalid_reg;
    assign median_ch.valid_samples     = cnt_out_reg;

endmodule

FILE: src/swm_checker.sv
`include "sliding_window_median_top_defines.svh"

module swm_checker
    import swm_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic signed [MED_BITS-1:0] median_half_units,
    input logic                       median_valid,
    input logic [CNT_BITS-1:0]        valid_samples
);

    `SWM_ASSERT_SAME(a_valid_matches_count, out_valid, median_valid == (valid_samples != '0))
    `SWM_ASSERT_SAME(a_count_in_range, out_valid, valid_samples <= CNT_BITS'(MAX_WINDOW))
    `SWM_ASSERT_SAME(a_empty_is_zero, out_valid && !median_valid, median_half_units == '0)
    `SWM_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready,
        out_valid && $stable(median_half_units) && $stable(valid_samples))

endmodule

bind sliding_window_median_top swm_checker u_swm_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (median_ch.valid),
    .out_ready         (median_ch.ready),
    .median_half_units (median_ch.median_half_units),
    .median_valid      (median_ch.median_valid),
    .valid_samples     (median_ch.valid_samples)
);
